### sv/tgd_pkg.sv
package tgd_pkg;

  // Defaults for the top-level parameters.
  localparam int DIM_MAX_DEF   = 64;
  localparam int ACC_WIDTH_DEF = 32;

  // Operation codes of an input word.
  localparam logic [1:0] OP_DEPOSIT    = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_READ_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_DEPOSITED = 3'd0;
  localparam logic [2:0] ST_SKIPPED   = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_READ_DONE = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z    = 3'd2;
  localparam logic [2:0] CFG_RECIP_PITCH = 3'd3;
  localparam logic [2:0] CFG_SIZE_X      = 3'd4;
  localparam logic [2:0] CFG_SIZE_Y      = 3'd5;
  localparam logic [2:0] CFG_SIZE_Z      = 3'd6;
  localparam logic [2:0] CFG_ELEMENT     = 3'd7;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] atom_x;
    logic signed [31:0] atom_y;
    logic signed [31:0] atom_z;
    logic [6:0]         atom_element;
    logic [15:0]        atom_occupancy;
    logic [17:0]        voxel_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] voxel_value;
  } result_t;

  // Per-axis grid coordinate.
  typedef struct packed {
    logic        outside;
    logic [24:0] corner;
    logic [15:0] frac;
  } axis_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_AXIS,
    S_BASE,
    S_C1,
    S_C2,
    S_C3,
    S_C4,
    S_MOD,
    S_REM,
    S_RD1,
    S_RD2
  } state_t;

endpackage

### sv/tgd_store.sv
module tgd_store #(
  parameter int AW = 18,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [2**AW];

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### sv/tgd_axis.sv
module tgd_axis (
  input  logic signed [31:0] pos,
  input  logic signed [31:0] org,
  input  logic [23:0]        inv,
  input  logic [8:0]         eff_size,
  output tgd_pkg::axis_t     coord
);

  logic signed [32:0] d;
  logic signed [24:0] inv_s;
  logic signed [57:0] g;
  logic [24:0]        lim;

  // Offset from the origin times the inverse spacing, 32 fraction bits.
  assign d     = {pos[31], pos} - {org[31], org};
  assign inv_s = $signed({1'b0, inv});
  assign g     = d * inv_s;
  assign lim   = 25'(eff_size) - 25'd1;

  // The lower corner must leave room for the upper one.
  assign coord.outside = g[57] | (eff_size < 9'd2) | (g[56:32] >= lim);
  assign coord.corner  = g[56:32];
  assign coord.frac    = g[31:16];

endmodule

### sv/trilinear_grid_deposit.sv
// Cloud-in-cell deposit of atoms onto a 3-D accumulator grid.
// Input words are taken on start while busy is low. A deposit word is
// checked against element_select, mapped to a grid corner one axis a cycle
// through a shared multiplier, and its eight trilinear weights are added
// into the store one corner at a time (read, three multiply stages, write).
// A read word returns one voxel; read-and-clear also writes it back to zero.
// Each word gives exactly one result, shown for one cycle with result_valid
// in the first cycle that busy is low again; the receiver cannot stall it.
// Skipped words end at decode, outside ones after the axes. A read reduces
// the voxel index modulo the store depth by a reciprocal multiply, a
// remainder step and one compare and subtract. The next word may start
// in the cycle result_valid is high. The configuration channel is always
// ready; the user must write it only while idle, which the block does not
// enforce. After reset the store is swept to zero, one entry a cycle, over
// DIM_MAX^3 entries (262144 by default); busy is high during the sweep.
module trilinear_grid_deposit #(
  parameter int DIM_MAX   = tgd_pkg::DIM_MAX_DEF,
  parameter int ACC_WIDTH = tgd_pkg::ACC_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tgd_pkg::in_word_t in_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              result_valid,
  output tgd_pkg::result_t  result
);

  localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DIM_MAX);
  localparam logic [24:0] DEPTH_V = 25'(DEPTH);
  localparam logic [35:0] RECIP   = 36'((64'd1 << 36) / 64'(DEPTH));
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  tgd_pkg::state_t state, state_next;

  // Configuration registers.
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [23:0]        recip_pitch;
  logic [6:0]         size_x, size_y, size_z;
  logic [6:0]         element_select;

  // Working registers.
  tgd_pkg::in_word_t in_q;
  logic [1:0]        axis_cnt;
  logic [2:0]        corner;
  logic [AW-1:0]     clr_addr;
  logic [CW-1:0]     cx, cy, cz;
  logic [15:0]       fx, fy, fz;
  logic              outside;
  logic [AW-1:0]     base;
  logic [32:0]       p1;
  logic [48:0]       p2;
  logic [64:0]       p3;
  logic              sat;
  logic [17:0]       rem;
  logic [17:0]       quot;

  // Control.
  logic              fin;
  logic [2:0]        fin_status;
  logic [31:0]       fin_value;
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic [ACC_WIDTH-1:0] mem_wdata, mem_rdata;

  // Axis datapath.
  logic signed [31:0] ax_pos, ax_org;
  logic [6:0]         ax_size;
  logic [8:0]         ax_eff;
  tgd_pkg::axis_t     ax_coord;

  logic [16:0]          wx, wy, wz;
  logic [AW-1:0]        corner_addr;
  logic [17:0]          weight;
  logic [ACC_WIDTH:0]   sum;
  logic [53:0]          quot_prod;
  logic [42:0]          rem_prod;
  logic [24:0]          rem_ext;
  logic [17:0]          rem_fix;
  logic [63:0]          rd_ext;
  logic [31:0]          rd_value;

  assign cfg_ready = 1'b1;
  assign busy      = (state != tgd_pkg::S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      origin_z       <= '0;
      recip_pitch    <= 24'h010000;
      size_x         <= 7'd64;
      size_y         <= 7'd64;
      size_z         <= 7'd64;
      element_select <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tgd_pkg::CFG_ORIGIN_X:    origin_x       <= cfg_data;
        tgd_pkg::CFG_ORIGIN_Y:    origin_y       <= cfg_data;
        tgd_pkg::CFG_ORIGIN_Z:    origin_z       <= cfg_data;
        tgd_pkg::CFG_RECIP_PITCH: recip_pitch    <= cfg_data[23:0];
        tgd_pkg::CFG_SIZE_X:      size_x         <= cfg_data[6:0];
        tgd_pkg::CFG_SIZE_Y:      size_y         <= cfg_data[6:0];
        tgd_pkg::CFG_SIZE_Z:      size_z         <= cfg_data[6:0];
        tgd_pkg::CFG_ELEMENT:     element_select <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Axis selection for the shared coordinate multiplier.
  always_comb begin
    case (axis_cnt)
      2'd0: begin
        ax_pos = in_q.atom_x; ax_org = origin_x; ax_size = size_x;
      end
      2'd1: begin
        ax_pos = in_q.atom_y; ax_org = origin_y; ax_size = size_y;
      end
      default: begin
        ax_pos = in_q.atom_z; ax_org = origin_z; ax_size = size_z;
      end
    endcase
    ax_eff = (9'(ax_size) > 9'(DIM_MAX)) ? 9'(DIM_MAX) : 9'(ax_size);
  end

  tgd_axis u_axis (
    .pos      (ax_pos),
    .org      (ax_org),
    .inv      (recip_pitch),
    .eff_size (ax_eff),
    .coord    (ax_coord)
  );

  // Corner weights and address.
  assign wx = corner[0] ? {1'b0, fx} : 17'h10000 - {1'b0, fx};
  assign wy = corner[1] ? {1'b0, fy} : 17'h10000 - {1'b0, fy};
  assign wz = corner[2] ? {1'b0, fz} : 17'h10000 - {1'b0, fz};
  assign corner_addr = base + AW'(corner[2]) * AW'(DIM_MAX * DIM_MAX)
                     + AW'(corner[1]) * AW'(DIM_MAX) + AW'(corner[0]);
  assign weight = p3[64:47];

  // Saturating accumulate.
  assign sum = {1'b0, mem_rdata} + (ACC_WIDTH + 1)'(weight);

  // Modulo reduction: the reciprocal estimate of the quotient is low by at
  // most one, so one compare and subtract finishes the remainder.
  assign quot_prod = 54'(rem) * 54'(RECIP);
  assign rem_prod  = 43'(quot) * 43'(DEPTH_V);
  assign rem_ext   = 25'(rem);
  assign rem_fix   = (rem_ext >= DEPTH_V) ? 18'(rem_ext - DEPTH_V) : rem;

  // Read clamp to the 32-bit result field.
  assign rd_ext   = 64'(mem_rdata);
  assign rd_value = (rd_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd_ext[31:0];

  tgd_store #(.AW(AW), .DW(ACC_WIDTH)) u_store (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory control and result selection.
  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_status = tgd_pkg::ST_DEPOSITED;
    fin_value  = '0;
    mem_re     = 1'b0;
    mem_raddr  = corner_addr;
    mem_we     = 1'b0;
    mem_waddr  = corner_addr;
    mem_wdata  = '0;
    case (state)
      tgd_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = tgd_pkg::S_IDLE;
        end
      end
      tgd_pkg::S_IDLE: begin
        if (start) begin
          state_next = tgd_pkg::S_DECODE;
        end
      end
      tgd_pkg::S_DECODE: begin
        if (in_q.operation != tgd_pkg::OP_DEPOSIT) begin
          state_next = tgd_pkg::S_MOD;
        end else if (in_q.atom_element != element_select) begin
          fin        = 1'b1;
          fin_status = tgd_pkg::ST_SKIPPED;
          state_next = tgd_pkg::S_IDLE;
        end else begin
          state_next = tgd_pkg::S_AXIS;
        end
      end
      tgd_pkg::S_AXIS: begin
        if (axis_cnt == 2'd2) begin
          if (outside || ax_coord.outside) begin
            fin        = 1'b1;
            fin_status = tgd_pkg::ST_OUTSIDE;
            state_next = tgd_pkg::S_IDLE;
          end else begin
            state_next = tgd_pkg::S_BASE;
          end
        end
      end
      tgd_pkg::S_BASE: state_next = tgd_pkg::S_C1;
      tgd_pkg::S_C1: begin
        mem_re     = 1'b1;
        state_next = tgd_pkg::S_C2;
      end
      tgd_pkg::S_C2: state_next = tgd_pkg::S_C3;
      tgd_pkg::S_C3: state_next = tgd_pkg::S_C4;
      tgd_pkg::S_C4: begin
        mem_we    = 1'b1;
        mem_wdata = sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0];
        if (corner == 3'd7) begin
          fin        = 1'b1;
          fin_status = (sat || sum[ACC_WIDTH]) ? tgd_pkg::ST_SATURATED
                                               : tgd_pkg::ST_DEPOSITED;
          state_next = tgd_pkg::S_IDLE;
        end else begin
          state_next = tgd_pkg::S_C1;
        end
      end
      tgd_pkg::S_MOD: state_next = tgd_pkg::S_REM;
      tgd_pkg::S_REM: state_next = tgd_pkg::S_RD1;
      tgd_pkg::S_RD1: begin
        mem_re     = 1'b1;
        mem_raddr  = AW'(rem_fix);
        state_next = tgd_pkg::S_RD2;
      end
      tgd_pkg::S_RD2: begin
        fin        = 1'b1;
        fin_status = tgd_pkg::ST_READ_DONE;
        fin_value  = rd_value;
        mem_we     = (in_q.operation == tgd_pkg::OP_READ_CLEAR);
        mem_waddr  = AW'(rem);
        state_next = tgd_pkg::S_IDLE;
      end
      default: state_next = tgd_pkg::S_IDLE;
    endcase
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      tgd_pkg::S_IDLE: begin
        in_q     <= in_word;
        axis_cnt <= 2'd0;
        outside  <= 1'b0;
        corner   <= 3'd0;
        sat      <= 1'b0;
        rem      <= in_word.voxel_index;
      end
      tgd_pkg::S_AXIS: begin
        axis_cnt <= axis_cnt + 2'd1;
        outside  <= outside | ax_coord.outside;
        case (axis_cnt)
          2'd0: begin
            cx <= ax_coord.corner[CW-1:0]; fx <= ax_coord.frac;
          end
          2'd1: begin
            cy <= ax_coord.corner[CW-1:0]; fy <= ax_coord.frac;
          end
          default: begin
            cz <= ax_coord.corner[CW-1:0]; fz <= ax_coord.frac;
          end
        endcase
      end
      tgd_pkg::S_BASE: begin
        base <= (AW'(cz) * AW'(DIM_MAX) + AW'(cy)) * AW'(DIM_MAX) + AW'(cx);
      end
      tgd_pkg::S_C1: p1 <= 33'(wx) * 33'(wy);
      tgd_pkg::S_C2: p2 <= 49'(p1) * 49'(wz);
      tgd_pkg::S_C3: p3 <= 65'(p2) * 65'(in_q.atom_occupancy);
      tgd_pkg::S_C4: begin
        sat    <= sat | sum[ACC_WIDTH];
        corner <= corner + 3'd1;
      end
      tgd_pkg::S_MOD: quot <= quot_prod[53:36];
      tgd_pkg::S_REM: rem <= rem - rem_prod[17:0];
      tgd_pkg::S_RD1: rem <= rem_fix;
      default: ;
    endcase
  end

  // Clear sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == tgd_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= fin;
    end
    if (fin) begin
      result.status      <= fin_status;
      result.voxel_value <= fin_value;
    end
  end

  // An accepted word always makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // A result appears only as the block returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!busy && $past(busy)))
    else $error("result outside the end of an item");

  // A deposit status never carries a voxel value.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != tgd_pkg::ST_READ_DONE) |->
      (result.voxel_value == 32'd0))
    else $error("nonzero value on a deposit result");

  // The store is written only by the sweep, a corner update or a clear.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == tgd_pkg::S_CLEAR || state == tgd_pkg::S_C4 ||
                state == tgd_pkg::S_RD2))
    else $error("unexpected store write");

endmodule

### tb/trilinear_grid_deposit_test.sv
module trilinear_grid_deposit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the density grid and the configuration, and predicts each result word.
  class grid_scoreboard;
    logic [31:0]        density[int];
    logic signed [31:0] origin[3];
    logic [23:0]        recip_pitch;
    logic [6:0]         dim[3];
    logic [6:0]         element;
    int                 last_base;
    tgd_pkg::result_t   expected_q[$];
    int                 errors;

    function void reset_state();
      density.delete();
      foreach (origin[a]) origin[a] = '0;
      foreach (dim[a]) dim[a] = 7'd64;
      recip_pitch = 24'd65536;
      element = '0;
      last_base = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [31:0] data);
      case (index)
        tgd_pkg::CFG_ORIGIN_X:    origin[0] = data;
        tgd_pkg::CFG_ORIGIN_Y:    origin[1] = data;
        tgd_pkg::CFG_ORIGIN_Z:    origin[2] = data;
        tgd_pkg::CFG_RECIP_PITCH: recip_pitch = data[23:0];
        tgd_pkg::CFG_SIZE_X:      dim[0] = data[6:0];
        tgd_pkg::CFG_SIZE_Y:      dim[1] = data[6:0];
        tgd_pkg::CFG_SIZE_Z:      dim[2] = data[6:0];
        default:                  element = data[6:0];
      endcase
    endfunction

    // Maps one axis position to its lower corner and 16-bit fraction; returns 0 if outside.
    function bit map_axis(logic signed [31:0] pos, int a, output int corner,
                          output longint unsigned frac);
      longint g;
      longint sz;
      g = (longint'(pos) - longint'(origin[a])) * longint'({1'b0, recip_pitch});
      sz = (dim[a] > tgd_pkg::DIM_MAX_DEF) ? tgd_pkg::DIM_MAX_DEF : dim[a];
      corner = 0;
      frac = 0;
      if (g < 0) return 0;
      if (sz < 2 || (g >>> 32) >= sz - 1) return 0;
      corner = int'(g >>> 32);
      frac = (g >>> 16) & 64'hFFFF;
      return 1;
    endfunction

    // Saturating add into one accumulator; returns 1 if it clipped.
    function bit add_weight(int addr, longint unsigned w);
      logic [31:0] acc;
      acc = density.exists(addr) ? density[addr] : '0;
      if (w > 64'hFFFF_FFFF - acc) begin
        density[addr] = 32'hFFFF_FFFF;
        return 1;
      end
      density[addr] = acc + w[31:0];
      return 0;
    endfunction

    // Notes an accepted input word and queues the result it must give.
    function void note(tgd_pkg::in_word_t w);
      tgd_pkg::result_t r;
      int c[3];
      longint unsigned f[3];
      longint unsigned wt[3][2];
      int addr;
      bit sat;
      r = '0;
      sat = 0;
      if (w.operation != tgd_pkg::OP_DEPOSIT) begin
        addr = w.voxel_index %
               (tgd_pkg::DIM_MAX_DEF * tgd_pkg::DIM_MAX_DEF * tgd_pkg::DIM_MAX_DEF);
        r.status = tgd_pkg::ST_READ_DONE;
        r.voxel_value = density.exists(addr) ? density[addr] : '0;
        if (w.operation == tgd_pkg::OP_READ_CLEAR) density[addr] = '0;
      end else if (w.atom_element != element) begin
        r.status = tgd_pkg::ST_SKIPPED;
      end else if (!map_axis(w.atom_x, 0, c[0], f[0]) || !map_axis(w.atom_y, 1, c[1], f[1]) ||
                   !map_axis(w.atom_z, 2, c[2], f[2])) begin
        r.status = tgd_pkg::ST_OUTSIDE;
      end else begin
        foreach (f[a]) begin
          wt[a][0] = 65536 - f[a];
          wt[a][1] = f[a];
        end
        last_base = (c[2] * tgd_pkg::DIM_MAX_DEF + c[1]) * tgd_pkg::DIM_MAX_DEF + c[0];
        for (int k = 0; k < 2; k++)
          for (int j = 0; j < 2; j++)
            for (int i = 0; i < 2; i++) begin
              addr = last_base + (k * tgd_pkg::DIM_MAX_DEF + j) * tgd_pkg::DIM_MAX_DEF + i;
              if (add_weight(addr, ((wt[0][i] * wt[1][j] * wt[2][k]) * w.atom_occupancy) >> 47))
                sat = 1;
            end
        r.status = sat ? tgd_pkg::ST_SATURATED : tgd_pkg::ST_DEPOSITED;
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compares a result word with the oldest expectation.
    task check(tgd_pkg::result_t r);
      tgd_pkg::result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d value %h", r.status,
                                  r.voxel_value));
        return;
      end
      e = expected_q.pop_front();
      if (r.status !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", r.status, e.status));
      if (r.voxel_value !== e.voxel_value)
        report_mismatch($sformatf("voxel_value %h, expected %h", r.voxel_value,
                                  e.voxel_value));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  tgd_pkg::in_word_t in_word = '0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic     result_valid;
  tgd_pkg::result_t result;

  grid_scoreboard sb = new();
  bit no_idle;

  trilinear_grid_deposit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
  );

  always #2 clk = ~clk;

  // Every result word is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check(result);
  end

  // Offers one word and holds it until the block takes it.
  task send(tgd_pkg::in_word_t w, int gap);
    in_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note(w);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_random_gap(tgd_pkg::in_word_t w);
    send(w, no_idle ? 0 : $urandom_range(0, 4));
  endtask

  // Stops the sender until every expected result has come and the block has settled.
  task wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // Writes one register; valid stays high for a following write.
  task write_reg(logic [2:0] index, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(index, data);
  endtask

  task configure(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz, logic [23:0] inv,
                 logic [6:0] sx, logic [6:0] sy, logic [6:0] sz, logic [6:0] el);
    write_reg(tgd_pkg::CFG_ORIGIN_X, ox);
    write_reg(tgd_pkg::CFG_ORIGIN_Y, oy);
    write_reg(tgd_pkg::CFG_ORIGIN_Z, oz);
    write_reg(tgd_pkg::CFG_RECIP_PITCH, {8'h0, inv});
    write_reg(tgd_pkg::CFG_SIZE_X, {25'h0, sx});
    write_reg(tgd_pkg::CFG_SIZE_Y, {25'h0, sy});
    write_reg(tgd_pkg::CFG_SIZE_Z, {25'h0, sz});
    write_reg(tgd_pkg::CFG_ELEMENT, {25'h0, el});
    cfg_valid <= 1'b0;
  endtask

  function tgd_pkg::in_word_t deposit_word(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic [6:0] el, logic [15:0] occ);
    tgd_pkg::in_word_t w;
    w = '0;
    w.operation = tgd_pkg::OP_DEPOSIT;
    w.atom_x = x;
    w.atom_y = y;
    w.atom_z = z;
    w.atom_element = el;
    w.atom_occupancy = occ;
    w.voxel_index = 18'($urandom());
    return w;
  endfunction

  function tgd_pkg::in_word_t read_word(logic [1:0] op, logic [17:0] index);
    tgd_pkg::in_word_t w;
    w = '0;
    w.operation = op;
    w.atom_x = $urandom();
    w.voxel_index = index;
    return w;
  endfunction

  // Picks a position that mostly falls inside the grid on one axis.
  function logic [31:0] pick_pos(int a);
    longint span;
    span = (longint'(sb.dim[a] > 1 ? sb.dim[a] - 1 : 1) << 32) / (sb.recip_pitch + 1);
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    if (span < 1) span = 1;
    return sb.origin[a] + 32'(longint'({$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF) % span);
  endfunction

  // Mostly in-grid deposits of the selected element, with reads near the last deposit.
  function tgd_pkg::in_word_t random_word();
    int pick;
    int offs[8] = '{0, 1, 64, 65, 4096, 4097, 4160, 4161};
    pick = $urandom_range(0, 99);
    if (pick < 20)
      return read_word(2'($urandom_range(1, 3)), (pick < 4) ? 18'($urandom()) :
                       18'(sb.last_base + offs[$urandom_range(0, 7)]));
    if (pick < 28)
      return deposit_word(pick_pos(0), pick_pos(1), pick_pos(2), 7'($urandom()),
                          16'($urandom_range(0, 32768)));
    if (pick < 36)
      return deposit_word($urandom(), $urandom(), $urandom(), sb.element, 16'($urandom()));
    return deposit_word(pick_pos(0), pick_pos(1), pick_pos(2), sb.element,
                        (pick < 45) ? 16'($urandom()) : 16'($urandom_range(0, 32768)));
  endfunction

  task random_phase(int count);
    no_idle = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_random_gap(random_word());
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset configuration.
    no_idle = 0;
    send_random_gap(deposit_word(32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 7'd0, 16'd32768));
    send_random_gap(read_word(tgd_pkg::OP_READ, 18'((3 * 64 + 2) * 64 + 1)));
    send_random_gap(read_word(tgd_pkg::OP_READ, 18'((3 * 64 + 2) * 64 + 2)));
    send_random_gap(read_word(tgd_pkg::OP_READ_CLEAR, 18'((4 * 64 + 3) * 64 + 2)));
    send_random_gap(read_word(tgd_pkg::OP_READ, 18'((4 * 64 + 3) * 64 + 2)));
    send_random_gap(read_word(2'd3, 18'((3 * 64 + 2) * 64 + 1)));
    send_random_gap(read_word(tgd_pkg::OP_READ, 18'h3FFFF));
    send_random_gap(deposit_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 7'd5, 16'd100));
    send_random_gap(deposit_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 7'd127, 16'd1));
    send_random_gap(deposit_word(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 7'd0, 16'd1000));
    send_random_gap(deposit_word(32'h003F_0000, 32'h0001_0000, 32'h0001_0000, 7'd0, 16'd1000));
    send_random_gap(deposit_word(32'h003E_FFFF, 32'h003E_FFFF, 32'h003E_FFFF, 7'd0, 16'hFFFF));
    send_random_gap(read_word(tgd_pkg::OP_READ_CLEAR, 18'h3FFFF));
    send_random_gap(deposit_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 7'd0, 16'd0));
    send_random_gap(deposit_word(32'h7FFF_FFFF, 32'h0, 32'h0, 7'd0, 16'd32768));
    send_random_gap(deposit_word(32'h8000_0000, 32'h0, 32'h0, 7'd0, 16'd32768));
    send_random_gap(deposit_word(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 7'd0, 16'd32768));
    send_random_gap(read_word(tgd_pkg::OP_READ, 18'd0));
    send_random_gap(read_word(tgd_pkg::OP_READ_CLEAR, 18'd0));

    // Zero spacing puts every atom on corner 0, back to back.
    wait_idle();
    configure(32'h0, 32'h0, 32'h0, 24'd0, 7'd64, 7'd64, 7'd64, 7'd0);
    for (int n = 0; n < 20; n++)
      send(deposit_word($urandom(), $urandom(), $urandom(), 7'd0, 16'hFFFF), 0);
    send_random_gap(read_word(tgd_pkg::OP_READ, 18'd1));
    send_random_gap(read_word(tgd_pkg::OP_READ_CLEAR, 18'd0));
    send_random_gap(read_word(tgd_pkg::OP_READ, 18'd0));

    // Random phases under several grid settings, the extremes among them.
    wait_idle();
    configure(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 24'd65536, 7'd64, 7'd64, 7'd64, 7'd3);
    random_phase(120);
    wait_idle();
    configure(32'h8000_0000, 32'h7FFF_0000, 32'h0, 24'd131072, 7'd2, 7'd2, 7'd2, 7'd127);
    random_phase(100);
    wait_idle();
    configure(32'h0, 32'h0, 32'h0, 24'd65536, 7'd127, 7'd1, 7'd0, 7'd0);
    random_phase(40);
    wait_idle();
    configure(32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 7'd37, 7'd5, 7'd64, 7'd64);
    random_phase(110);
    wait_idle();
    configure($urandom(), $urandom(), $urandom(), 24'd1, 7'd127, 7'd100, 7'd65, 7'd1);
    random_phase(100);
    wait_idle();
    configure(32'($urandom_range(0, 20)) << 16, 32'h0, 32'h0, 24'($urandom_range(16384, 300000)),
              7'($urandom_range(2, 64)), 7'($urandom_range(2, 64)), 7'($urandom_range(2, 64)),
              7'($urandom()));
    random_phase(160);

    // Drain and let the block settle before the verdict.
    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS trilinear_grid_deposit");
    end else begin
      $display("FAIL trilinear_grid_deposit");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #40ms;
    $display("FAIL trilinear_grid_deposit");
    $finish;
  end
endmodule

### trilinear_grid_deposit.f
sv/tgd_pkg.sv
sv/tgd_store.sv
sv/tgd_axis.sv
sv/trilinear_grid_deposit.sv
tb/trilinear_grid_deposit_test.sv
